[hw/rtl/mtf_pkg.sv]
// Shared types and constants of the move-to-front list block.
package mtf_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned FoundW   = 4;
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      cmp_en;
  } cell_ctl_t;

  typedef struct packed {
    action_e                   action;
    logic signed [DataW-1:0]   value;
  } in_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   removed_value;
    logic        [FoundW-1:0]  found_index;
    logic        [CountW-1:0]  entry_count;
  } out_t;

endpackage

[hw/rtl/mtf_cell.sv]
// One list cell: holds an entry, compares it and trades it with its neighbors.
module mtf_cell (
  input  logic                              clk_i,
  input  mtf_pkg::cell_ctl_t                ctl_i,
  input  logic signed [mtf_pkg::DataW-1:0]  prev_i,
  input  logic signed [mtf_pkg::DataW-1:0]  next_i,
  input  logic signed [mtf_pkg::DataW-1:0]  load_i,
  input  logic signed [mtf_pkg::DataW-1:0]  cmp_i,
  output logic signed [mtf_pkg::DataW-1:0]  data_o,
  output logic                              match_o
);
  import mtf_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    match_q, match_d;

  always_comb begin
    unique case (ctl_i.cmd)
      CELL_HOLD:      data_d = data_q;
      CELL_LOAD:      data_d = load_i;
      CELL_TAKE_PREV: data_d = prev_i;
      CELL_TAKE_NEXT: data_d = next_i;
      default:        data_d = data_q;
    endcase
    match_d = ctl_i.cmp_en ? (data_q == cmp_i) : match_q;
  end

  // Entries are undefined until written, so neither register is reset.
  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

[hw/rtl/move_to_front_list_top.sv]
// Top level of the move-to-front self-organizing list.
//
// A user drives one command beat at a time on in_i (action and value) and
// raises start_i; the beat is taken at a rising edge where start_i is high
// and busy_o is low. Every beat yields exactly one result beat on result_o,
// marked by done_o for exactly one cycle; the receiver cannot hold it off.
//
// Latency and throughput: an accepted beat spends one cycle in compare (all
// cells test their entry against the value in parallel) and one cycle in
// update (priority pick of the first hit, then one shift step along the
// cell row). The result appears in the cycle after the update, which is
// also the first cycle in which a new beat may be taken, so one item takes
// two cycles and the block sustains one item every two cycles. The shift
// step of the cell row is what sets that figure.
//
// Reset clears the entry count and the control state; the stored entries
// stay undefined, but only positions below the count are ever read, so no
// clearing pass is needed and the block is ready in the first cycle.
module move_to_front_list_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mtf_pkg::in_t   in_i,
  output logic           busy_o,
  output logic           done_o,
  output mtf_pkg::out_t  result_o
);
  import mtf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                  state_q, state_d;
  logic                    done_q;
  out_t                    result_q, result_d;
  logic [CntW-1:0]         count_q, count_d;
  action_e                 act_q;
  logic signed [DataW-1:0] val_q;

  logic                    accept;
  cell_ctl_t               cell_ctl   [Capacity];
  logic signed [DataW-1:0] cell_data  [Capacity];
  logic                    cell_match [Capacity];
  logic [Capacity-1:0]     hit_vec;
  logic                    hit_any;
  logic [IdxW-1:0]         hit_pos;

  assign accept = start_i && (state_q == S_IDLE);

  // The cell row. Cell zero is the front of the list.
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic signed [DataW-1:0] prev_w, next_w;
    if (g == 0) begin : g_front
      assign prev_w = val_q;
    end else begin : g_mid_prev
      assign prev_w = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_back
      assign next_w = cell_data[g];
    end else begin : g_mid_next
      assign next_w = cell_data[g+1];
    end

    mtf_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .load_i  (val_q),
      .cmp_i   (in_i.value),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );

    // Only occupied positions may count as a hit.
    assign hit_vec[g] = cell_match[g] && (CntW'(g) < count_q);
  end

  // Priority pick of the hit nearest the front.
  always_comb begin
    hit_pos = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = IdxW'(i);
      end
    end
  end
  assign hit_any = |hit_vec;

  // Update step: pick the per-cell commands and build the result beat.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    result_d = result_q;
    for (int i = 0; i < Capacity; i++) begin
      cell_ctl[i].cmd    = CELL_HOLD;
      cell_ctl[i].cmp_en = accept;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d                = S_IDLE;
        result_d.status        = ST_OK;
        result_d.removed_value = '0;
        result_d.found_index   = '0;
        unique case (act_q)
          ACT_INSERT: begin
            if (count_q >= CntW'(Capacity)) begin
              result_d.status = ST_FULL;
            end else begin
              cell_ctl[0].cmd = CELL_LOAD;
              for (int i = 1; i < Capacity; i++) begin
                cell_ctl[i].cmd = CELL_TAKE_PREV;
              end
              count_d = count_q + CntW'(1);
            end
          end
          ACT_REMOVE: begin
            if (count_q == '0) begin
              result_d.status = ST_EMPTY;
            end else begin
              for (int i = 0; i < Capacity; i++) begin
                cell_ctl[i].cmd = CELL_TAKE_NEXT;
              end
              result_d.removed_value = cell_data[0];
              count_d = count_q - CntW'(1);
            end
          end
          ACT_FIND: begin
            if (!hit_any) begin
              result_d.status = ST_NOT_FOUND;
            end else begin
              // Entries in front of the hit move back by one; the hit
              // position is overwritten and the value goes to the front.
              cell_ctl[0].cmd = CELL_LOAD;
              for (int i = 1; i < Capacity; i++) begin
                if (IdxW'(i) <= hit_pos) begin
                  cell_ctl[i].cmd = CELL_TAKE_PREV;
                end
              end
              result_d.found_index = FoundW'(hit_pos);
            end
          end
          ACT_NOP: begin
            result_d.status = ST_OK;
          end
          default: begin
            result_d.status = ST_OK;
          end
        endcase
        result_d.entry_count = CountW'(count_d);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      count_q  <= '0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= (state_q == S_EXEC);
      count_q  <= count_d;
      result_q <= result_d;
    end
  end

  // The command beat is held for the update step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_i.action;
      val_q <= in_i.value;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // Every update step is followed by exactly one result beat.
  a_exec_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o)
    else $error("update step not followed by a result beat");

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  // A full report leaves the list at capacity.
  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |-> (count_q == CntW'(Capacity)))
    else $error("full reported below capacity");

  // The count moves by at most one per item and only after an update step.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_o)
    else $error("entry count changed outside an update step");

endmodule

[tb/tb.sv]
// Self-checking testbench of the move-to-front list: directed table, then random beats.
`timescale 1ns / 100ps

module tb;
  import mtf_pkg::*;

  localparam int unsigned NumRandom = 1200;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxReports = 10;

  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;

  // One row of the directed table. Where fixed is set, want is the known answer;
  // otherwise the row is checked against the list predictor.
  typedef struct packed {
    in_t  beat;
    logic fixed;
    out_t want;
  } dir_row_t;

  localparam int unsigned NumDir = 26;

  localparam dir_row_t DirRows [NumDir] = '{
    // Empty list: remove and find both fail, the spare action code does nothing.
    '{'{ACT_REMOVE, 32'sh0000_0000}, 1'b1, '{ST_EMPTY,     32'sh0, 4'd0,  5'd0}},
    '{'{ACT_FIND,   32'sh0000_0000}, 1'b1, '{ST_NOT_FOUND, 32'sh0, 4'd0,  5'd0}},
    '{'{ACT_NOP,    32'shFFFF_FFFF}, 1'b1, '{ST_OK,        32'sh0, 4'd0,  5'd0}},
    // Extreme values, a find one deep, a find at the front, then a pop.
    '{'{ACT_INSERT, MaxVal},         1'b1, '{ST_OK,        32'sh0, 4'd0,  5'd1}},
    '{'{ACT_INSERT, MinVal},         1'b1, '{ST_OK,        32'sh0, 4'd0,  5'd2}},
    '{'{ACT_FIND,   MaxVal},         1'b1, '{ST_OK,        32'sh0, 4'd1,  5'd2}},
    '{'{ACT_FIND,   MaxVal},         1'b1, '{ST_OK,        32'sh0, 4'd0,  5'd2}},
    '{'{ACT_REMOVE, 32'sh0000_0000}, 1'b1, '{ST_OK,        MaxVal, 4'd0,  5'd1}},
    // Fill up to capacity, with one value held twice.
    '{'{ACT_INSERT, 32'sh0000_0000}, 1'b0, '0},
    '{'{ACT_INSERT, 32'shFFFF_FFFF}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh5555_5555}, 1'b0, '0},
    '{'{ACT_INSERT, 32'shAAAA_AAAA}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh1234_5678}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh5555_5555}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh0000_0001}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh8000_0001}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh7FFF_FFFE}, 1'b0, '0},
    '{'{ACT_INSERT, 32'shFEDC_BA98}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh0000_FFFF}, 1'b0, '0},
    '{'{ACT_INSERT, 32'shFFFF_0000}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh3C3C_3C3C}, 1'b0, '0},
    '{'{ACT_INSERT, 32'shC3C3_C3C3}, 1'b0, '0},
    '{'{ACT_INSERT, 32'sh0000_0002}, 1'b0, '0},
    // Full list: insert refused, find of the deepest entry, then a duplicate.
    '{'{ACT_INSERT, 32'sh0000_0003}, 1'b1, '{ST_FULL,      32'sh0, 4'd0,  5'd16}},
    '{'{ACT_FIND,   MinVal},         1'b1, '{ST_OK,        32'sh0, 4'd15, 5'd16}},
    '{'{ACT_FIND,   32'sh5555_5555}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  in_i;
  logic busy_o;
  logic done_o;
  out_t result_o;

  move_to_front_list_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Predicted list contents, front at position zero, and its fill level.
  logic signed [DataW-1:0] list_q [Capacity];
  int unsigned fill;

  out_t pending_results [$];

  int unsigned n_sent, n_checked, n_mismatch, n_unexpected;
  int unsigned n_hit, n_miss, n_full, n_empty, peak_fill;
  int unsigned idle_cycles;
  int unsigned phase;
  bit          burst_mode;

  // Applies one command beat to the predicted list and returns its result beat.
  function automatic out_t mtf_apply(input in_t beat);
    out_t        r;
    int unsigned pos;
    bit          hit;
    r   = '0;
    pos = 0;
    hit = 1'b0;
    r.status = ST_OK;
    case (beat.action)
      ACT_INSERT: begin
        if (fill >= Capacity) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          for (int i = fill; i > 0; i--) list_q[i] = list_q[i-1];
          list_q[0] = beat.value;
          fill++;
        end
      end
      ACT_REMOVE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.removed_value = list_q[0];
          for (int i = 0; i + 1 < fill; i++) list_q[i] = list_q[i+1];
          fill--;
        end
      end
      ACT_FIND: begin
        for (int i = 0; i < fill; i++) begin
          if (!hit && list_q[i] == beat.value) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
          n_miss++;
        end else begin
          for (int i = pos; i > 0; i--) list_q[i] = list_q[i-1];
          list_q[0] = beat.value;
          r.found_index = FoundW'(pos);
          n_hit++;
        end
      end
      default: ;
    endcase
    r.entry_count = CountW'(fill);
    if (fill > peak_fill) peak_fill = fill;
    return r;
  endfunction

  // Draws a value: often one already in the list for finds, often a duplicate-prone
  // value (an extreme or a small one), otherwise a fully random word.
  function automatic logic signed [DataW-1:0] pick_value(input action_e act);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (act == ACT_FIND && fill != 0 && roll < 60) begin
      return list_q[$urandom_range(0, fill - 1)];
    end
    if (roll < 80) begin
      case ($urandom_range(0, 6))
        0:       return MinVal;
        1:       return MaxVal;
        2:       return -32'sd1;
        3:       return -32'sd2;
        default: return DataW'($urandom_range(0, 2));
      endcase
    end
    return $urandom();
  endfunction

  // The phase biases the mix toward filling, draining, or a balanced mix,
  // so that both the full and the empty corners are visited often.
  function automatic in_t pick_beat();
    in_t         b;
    int unsigned roll, ins_pct, rem_pct;
    case (phase)
      0:       begin ins_pct = 55; rem_pct = 15; end
      1:       begin ins_pct = 15; rem_pct = 55; end
      default: begin ins_pct = 30; rem_pct = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 3) b.action = ACT_NOP;
    else if (roll < 3 + ins_pct) b.action = ACT_INSERT;
    else if (roll < 3 + ins_pct + rem_pct) b.action = ACT_REMOVE;
    else b.action = ACT_FIND;
    b.value = pick_value(b.action);
    return b;
  endfunction

  // Offers one beat, after a random gap unless in burst mode, and returns at the edge that takes it.
  task automatic send_beat(input in_t beat, input bit fixed, input out_t fixed_want);
    int unsigned gap;
    out_t        want;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= beat;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    want = mtf_apply(beat);
    if (fixed) want = fixed_want;
    pending_results.push_back(want);
    n_sent++;
  endtask

  // Result checker: every done beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= MaxReports) begin
          $display("Unexpected result beat: st=%0d rm=%h idx=%0d cnt=%0d",
                   result_o.status, result_o.removed_value,
                   result_o.found_index, result_o.entry_count);
        end
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result_o.status !== want.status ||
            result_o.removed_value !== want.removed_value ||
            result_o.found_index !== want.found_index ||
            result_o.entry_count !== want.entry_count) begin
          n_mismatch++;
          if (n_mismatch + n_unexpected <= MaxReports) begin
            $display("Mismatch on result %0d: expected st=%0d rm=%h idx=%0d cnt=%0d, got st=%0d rm=%h idx=%0d cnt=%0d",
                     n_checked, want.status, want.removed_value, want.found_index,
                     want.entry_count, result_o.status, result_o.removed_value,
                     result_o.found_index, result_o.entry_count);
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat moving in either direction ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timeout: no beat moved for %0d cycles, %0d results still due",
                 IdleLimit, pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned errors;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    in_i         = '0;
    fill         = 0;
    idle_cycles  = 0;
    phase        = 2;
    burst_mode   = 1'b0;
    n_sent       = 0;
    n_checked    = 0;
    n_mismatch   = 0;
    n_unexpected = 0;
    n_hit        = 0;
    n_miss       = 0;
    n_full       = 0;
    n_empty      = 0;
    peak_fill    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[k]) begin
      send_beat(DirRows[k].beat, DirRows[k].fixed, DirRows[k].want);
    end

    // Random part in chunks; each chunk draws a mix and whether it runs back to back.
    for (int k = 0; k < NumRandom; k++) begin
      if (k % 60 == 0) begin
        phase      = $urandom_range(0, 2);
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      send_beat(pick_beat(), 1'b0, '0);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    errors = n_mismatch + n_unexpected + pending_results.size();
    $display("Covered %0d beats (%0d directed): %0d find hits, %0d misses, %0d full inserts, %0d empty removes, peak fill %0d",
             n_sent, NumDir, n_hit, n_miss, n_full, n_empty, peak_fill);
    $display("Checked %0d results: %0d mismatches, %0d unexpected",
             n_checked, n_mismatch, n_unexpected);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[move_to_front_list_top.f]
hw/rtl/mtf_pkg.sv
hw/rtl/mtf_cell.sv
hw/rtl/move_to_front_list_top.sv
tb/tb.sv
